### hw/rtl/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg: shared types and codes of the block stream decoder
// Opcodes, status codes, decode phases and the command word that travels
// from the front end to the back end.
// ----------------------------------------------------------------------------
package lzd_pkg;

    localparam int ADDR_W = 16;   // history address field, covers the largest history

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_LIT_OVER  = 3'd1;
    localparam logic [2:0] ST_TRUNC_OFF = 3'd2;
    localparam logic [2:0] ST_BAD_OFF   = 3'd3;
    localparam logic [2:0] ST_BUSY      = 3'd4;

    localparam logic [2:0] PH_TOKEN     = 3'd0;
    localparam logic [2:0] PH_LIT_EXT   = 3'd1;
    localparam logic [2:0] PH_LITERALS  = 3'd2;
    localparam logic [2:0] PH_OFF_LO    = 3'd3;
    localparam logic [2:0] PH_OFF_HI    = 3'd4;
    localparam logic [2:0] PH_MATCH_EXT = 3'd5;
    localparam logic [2:0] PH_COPY      = 3'd6;

    localparam logic [3:0] NIB_EXT  = 4'd15;
    localparam logic [7:0] BYTE_EXT = 8'd255;

    // One result to produce. A copy reads history at raddr; a literal or a
    // status-only result takes lit_byte. wr stores the byte at waddr.
    typedef struct packed {
        logic              wr;
        logic              use_lit;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr;
        logic [7:0]        lit_byte;
        logic              byte_valid;
        logic [2:0]        status;
        logic              done;
    } t_cmd;

endpackage

### hw/rtl/lzd_if.sv
// ----------------------------------------------------------------------------
// lzd_if: stream channels of the block stream decoder
// Input channel carries compressed words, output channel decoded words.
// ----------------------------------------------------------------------------
interface lzd_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, opcode, data_byte, last_byte, input ready);
    modport sink   (input valid, opcode, data_byte, last_byte, output ready);
endinterface

interface lzd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       stream_done;
    modport source (output valid, out_byte, byte_valid, status, stream_done, input ready);
    modport sink   (input valid, out_byte, byte_valid, status, stream_done, output ready);
endinterface

### hw/rtl/lzd_ram.sv
// ----------------------------------------------------------------------------
// lzd_ram: generic single-write, single-read RAM
// Registered read; a read at the address being written returns old data.
// ----------------------------------------------------------------------------
module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

### hw/rtl/lzd_front.sv
// ----------------------------------------------------------------------------
// lzd_front: token parser of the block stream decoder
// Tracks the sequence phase, lengths and pointers, and turns each accepted
// word into at most one command for the back end.
// ----------------------------------------------------------------------------
module lzd_front import lzd_pkg::*; #(
    parameter int HISTORY_DEPTH = 65536,
    parameter int MIN_MATCH     = 4,
    parameter int LENGTH_BITS   = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lzd_in_if.sink i_in,
    input  logic i_q_ready,
    output logic o_push,
    output t_cmd o_cmd
);
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int BW = $clog2(HISTORY_DEPTH + 1);
    localparam int PW = 17;
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
    localparam logic [BW-1:0] BE_MAX    = BW'(HISTORY_DEPTH);
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic [2:0]             r_phase, n_phase;
    logic [LENGTH_BITS-1:0] r_lit, n_lit;
    logic [LENGTH_BITS-1:0] r_mr, n_mr;
    logic [3:0]             r_nib, n_nib;
    logic [15:0]            r_off, n_off;
    logic [AW-1:0]          r_wp, n_wp;
    logic [AW-1:0]          r_cp, n_cp;
    logic [BW-1:0]          r_be, n_be;
    logic                   r_ep, n_ep;
    logic                   r_err, n_err;
    logic [2:0]             r_code, n_code;

    logic          acc;
    logic [15:0]   off_full;
    logic [PW-1:0] diff;
    logic [PW-1:0] cp_calc;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
        return (p == LAST_ADDR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] a,
                                                       input logic [7:0] b);
        logic [LENGTH_BITS:0] s;
        s = {1'b0, a} + (LENGTH_BITS + 1)'(b);
        return s[LENGTH_BITS] ? LEN_MAX : s[LENGTH_BITS-1:0];
    endfunction

    assign acc      = i_in.valid & i_q_ready;
    assign i_in.ready = i_q_ready;
    assign off_full = {i_in.data_byte, r_off[7:0]};
    assign diff     = PW'(r_wp) - PW'(off_full);
    assign cp_calc  = diff[PW-1] ? diff + PW'(HISTORY_DEPTH) : diff;

    always_comb begin
        n_phase = r_phase; n_lit = r_lit; n_mr = r_mr; n_nib = r_nib; n_off = r_off;
        n_wp = r_wp; n_cp = r_cp; n_be = r_be; n_ep = r_ep; n_err = r_err; n_code = r_code;
        o_push = 1'b0;
        o_cmd  = '0;
        o_cmd.waddr = ADDR_W'(r_wp);
        o_cmd.raddr = ADDR_W'(r_cp);
        o_cmd.use_lit = 1'b1;
        if (acc) begin
            if (r_err) begin
                o_push = 1'b1;
                o_cmd.status = r_code;
            end else if (i_in.opcode == OP_DRAIN) begin
                if (r_phase == PH_COPY) begin
                    o_push = 1'b1;
                    o_cmd.wr = 1'b1;
                    o_cmd.use_lit = 1'b0;
                    o_cmd.byte_valid = 1'b1;
                    n_wp = adv(r_wp);
                    if (r_be != BE_MAX) n_be = r_be + 1'b1;
                    n_cp = adv(r_cp);
                    if (r_mr != '0) n_mr = r_mr - 1'b1;
                    if (n_mr == '0) begin
                        if (r_ep) begin
                            o_cmd.done = 1'b1;
                            n_phase = PH_TOKEN; n_be = '0; n_ep = 1'b0;
                            n_lit = '0; n_mr = '0;
                        end else begin
                            n_phase = PH_TOKEN;
                        end
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_TOKEN: begin
                        n_nib = i_in.data_byte[3:0];
                        if (i_in.data_byte[7:4] == NIB_EXT) begin
                            n_lit = LENGTH_BITS'(15);
                            if (i_in.last_byte) begin
                                n_err = 1'b1; n_code = ST_LIT_OVER;
                                o_push = 1'b1; o_cmd.status = ST_LIT_OVER;
                            end else begin
                                n_phase = PH_LIT_EXT;
                            end
                        end else if (i_in.data_byte[7:4] == 4'd0) begin
                            if (i_in.last_byte) begin
                                n_phase = PH_TOKEN; n_be = '0; n_ep = 1'b0;
                                n_lit = '0; n_mr = '0;
                                o_push = 1'b1; o_cmd.done = 1'b1;
                            end else begin
                                n_phase = PH_OFF_LO;
                            end
                        end else if (i_in.last_byte) begin
                            n_err = 1'b1; n_code = ST_LIT_OVER;
                            o_push = 1'b1; o_cmd.status = ST_LIT_OVER;
                        end else begin
                            n_lit = LENGTH_BITS'(i_in.data_byte[7:4]);
                            n_phase = PH_LITERALS;
                        end
                    end
                    PH_LIT_EXT: begin
                        n_lit = sat_add(r_lit, i_in.data_byte);
                        if (i_in.last_byte) begin
                            n_err = 1'b1; n_code = ST_LIT_OVER;
                            o_push = 1'b1; o_cmd.status = ST_LIT_OVER;
                        end else if (i_in.data_byte != BYTE_EXT) begin
                            n_phase = PH_LITERALS;
                        end
                    end
                    PH_LITERALS: begin
                        if (i_in.last_byte && r_lit > LENGTH_BITS'(1)) begin
                            n_err = 1'b1; n_code = ST_LIT_OVER;
                            o_push = 1'b1; o_cmd.status = ST_LIT_OVER;
                        end else begin
                            o_push = 1'b1;
                            o_cmd.wr = 1'b1;
                            o_cmd.lit_byte = i_in.data_byte;
                            o_cmd.byte_valid = 1'b1;
                            n_wp = adv(r_wp);
                            if (r_be != BE_MAX) n_be = r_be + 1'b1;
                            if (r_lit != '0) n_lit = r_lit - 1'b1;
                            if (n_lit == '0) begin
                                if (i_in.last_byte) begin
                                    o_cmd.done = 1'b1;
                                    n_phase = PH_TOKEN; n_be = '0; n_ep = 1'b0;
                                    n_lit = '0; n_mr = '0;
                                end else begin
                                    n_phase = PH_OFF_LO;
                                end
                            end
                        end
                    end
                    PH_OFF_LO: begin
                        n_off = {8'd0, i_in.data_byte};
                        if (i_in.last_byte) begin
                            n_err = 1'b1; n_code = ST_TRUNC_OFF;
                            o_push = 1'b1; o_cmd.status = ST_TRUNC_OFF;
                        end else begin
                            n_phase = PH_OFF_HI;
                        end
                    end
                    PH_OFF_HI: begin
                        n_off = off_full;
                        if (off_full == 16'd0 || PW'(off_full) > PW'(r_be)) begin
                            n_err = 1'b1; n_code = ST_BAD_OFF;
                            o_push = 1'b1; o_cmd.status = ST_BAD_OFF;
                        end else begin
                            n_cp = cp_calc[AW-1:0];
                            n_mr = LENGTH_BITS'(r_nib) + LENGTH_BITS'(MIN_MATCH);
                            if (r_nib == NIB_EXT && !i_in.last_byte) begin
                                n_phase = PH_MATCH_EXT;
                            end else begin
                                n_phase = PH_COPY;
                                n_ep = i_in.last_byte;
                            end
                        end
                    end
                    PH_MATCH_EXT: begin
                        n_mr = sat_add(r_mr, i_in.data_byte);
                        if (i_in.data_byte != BYTE_EXT || i_in.last_byte) begin
                            n_phase = PH_COPY;
                            n_ep = i_in.last_byte;
                        end
                    end
                    default: begin
                        n_err = 1'b1; n_code = ST_BUSY;
                        o_push = 1'b1; o_cmd.status = ST_BUSY;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOKEN; r_lit <= '0; r_mr <= '0; r_nib <= '0; r_off <= '0;
            r_wp <= '0; r_cp <= '0; r_be <= '0; r_ep <= 1'b0; r_err <= 1'b0;
            r_code <= ST_OK;
        end else begin
            r_phase <= n_phase; r_lit <= n_lit; r_mr <= n_mr; r_nib <= n_nib;
            r_off <= n_off; r_wp <= n_wp; r_cp <= n_cp; r_be <= n_be; r_ep <= n_ep;
            r_err <= n_err; r_code <= n_code;
        end
    end
endmodule

### hw/rtl/lzd_cmd_queue.sv
// ----------------------------------------------------------------------------
// lzd_cmd_queue: two-entry command queue
// Decouples the parser from the history back end.
// ----------------------------------------------------------------------------
module lzd_cmd_queue import lzd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);
    t_cmd       r_ent [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_ent[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0; r_rd <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

### hw/rtl/lzd_back.sv
// ----------------------------------------------------------------------------
// lzd_back: history back end of the block stream decoder
// Reads history for copies, stores every decoded byte and registers results.
// ----------------------------------------------------------------------------
module lzd_back import lzd_pkg::*; #(
    parameter int HISTORY_DEPTH = 65536
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    lzd_out_if.source o_out
);
    localparam int AW = $clog2(HISTORY_DEPTH);

    logic       r_b_v;
    t_cmd       r_b;
    logic       r_hit;
    logic [7:0] r_fwd;
    logic       r_o_v;
    logic [7:0] r_o_byte;
    logic       r_o_bv;
    logic [2:0] r_o_st;
    logic       r_o_done;

    logic       out_free, b_go, a_go;
    logic [7:0] ram_q, b_data;

    assign out_free = ~r_o_v | o_out.ready;
    assign b_go     = r_b_v & out_free;
    assign a_go     = i_valid & (~r_b_v | b_go);
    assign o_pop    = a_go;
    assign b_data   = r_b.use_lit ? r_b.lit_byte : (r_hit ? r_fwd : ram_q);

    lzd_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (b_go & r_b.wr),
        .i_waddr (r_b.waddr[AW-1:0]),
        .i_wdata (b_data),
        .i_re    (a_go),
        .i_raddr (i_cmd.raddr[AW-1:0]),
        .o_rdata (ram_q)
    );

    // A copy that reads the byte being stored in the same cycle takes it here.
    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_b   <= i_cmd;
            r_hit <= r_b_v & r_b.wr & (r_b.waddr[AW-1:0] == i_cmd.raddr[AW-1:0]);
            r_fwd <= b_data;
        end
        if (b_go) begin
            r_o_byte <= b_data;
            r_o_bv   <= r_b.byte_valid;
            r_o_st   <= r_b.status;
            r_o_done <= r_b.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (a_go)          r_b_v <= 1'b1;
            else if (b_go)     r_b_v <= 1'b0;
            if (b_go)          r_o_v <= 1'b1;
            else if (o_out.ready) r_o_v <= 1'b0;
        end
    end

    assign o_out.valid       = r_o_v;
    assign o_out.out_byte    = r_o_byte;
    assign o_out.byte_valid  = r_o_bv;
    assign o_out.status      = r_o_st;
    assign o_out.stream_done = r_o_done;
endmodule

### hw/rtl/lz_block_stream_decoder.sv
// ----------------------------------------------------------------------------
// lz_block_stream_decoder: LZ4-style block decompressor
// Parses compressed words, emits literals and copies matches from history.
// ----------------------------------------------------------------------------
// The decoder takes one word per cycle and gives one decoded word per cycle
// unless the output stalls. A word is either a compressed byte or a drain
// tick; each drain tick copies one pending match byte out of the history RAM.
// The front end parses tokens, lengths and offsets and checks errors in the
// cycle it accepts a word; every word that yields a result becomes a command
// in a two-entry queue. The back end reads the history RAM (one read and one
// write port) and stores every decoded byte; a result passes from the queue
// through a back-end stage register into the output register. Overlapping
// copies, even with an offset of one, run at full rate: a byte still on its
// way into the RAM is forwarded to the copy that needs it. Once an error is
// latched, every word returns the error status until reset.
module lz_block_stream_decoder import lzd_pkg::*; #(
    parameter int HISTORY_DEPTH = 65536,
    parameter int MIN_MATCH     = 4,
    parameter int LENGTH_BITS   = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lzd_in_if.sink    i_in,
    lzd_out_if.source o_out
);
    logic q_ready, push, q_valid, pop;
    t_cmd cmd_in, cmd_head;

    // Parser: all sequence state lives here.
    lzd_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MIN_MATCH     (MIN_MATCH),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (cmd_in)
    );

    // Short queue so the parser keeps taking words while the output stalls.
    lzd_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (cmd_head),
        .i_pop   (pop)
    );

    // History access and the output register.
    lzd_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (cmd_head),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule

### dv/lz_block_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// lz_block_stream_decoder_tb: self-checking bench of the block stream decoder
// Drives directed and random compressed streams with drain ticks, predicts
// every decoded word in a behavioral decoder and compares it in order.
// ----------------------------------------------------------------------------
module lz_block_stream_decoder_tb;
    import lzd_pkg::*;

    localparam int HIST = 65536;
    localparam int MINM = 4;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] status;
        logic       stream_done;
    } t_dec;

    // One row of the directed table. has_exp marks rows whose result is typed in.
    typedef struct packed {
        t_word w;
        logic  has_exp;
        logic  none_exp;
        t_dec  exp_dec;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    lzd_in_if  in_ch();
    lzd_out_if out_ch();

    lz_block_stream_decoder dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Shadow state of the decoder.
    logic [7:0]  hist_mem [HIST];
    logic [2:0]  ph;
    logic [31:0] lit_left, match_left;
    logic [3:0]  match_nib;
    logic [15:0] offs, wr_ptr, cp_ptr;
    int          emitted;
    logic        end_pend, err_on;
    logic [2:0]  err_code;

    t_dec  expected_q[$];
    int    fail_count = 0;
    int    words_sent = 0;
    int    words_decoded = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    stall_cycles = 0;
    int    quiet_cycles = 0;
    bit    stim_done = 0;

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [7:0] b);
        logic [32:0] s;
        s = {1'b0, a} + b;
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void keep_byte(logic [7:0] v);
        hist_mem[wr_ptr] = v;
        wr_ptr = wr_ptr + 1;
        if (emitted < HIST) emitted++;
    endfunction

    function automatic void close_block();
        ph = PH_TOKEN;
        emitted = 0;
        end_pend = 0;
        lit_left = 0;
        match_left = 0;
    endfunction

    function automatic t_dec mk(logic [7:0] b, logic v, logic [2:0] s, logic d);
        t_dec r;
        r.out_byte = b; r.byte_valid = v; r.status = s; r.stream_done = d;
        return r;
    endfunction

    function automatic void clear_decoder_state();
        ph = PH_TOKEN; lit_left = 0; match_left = 0; match_nib = 0; offs = 0;
        wr_ptr = 0; cp_ptr = 0; emitted = 0; end_pend = 0; err_on = 0;
        err_code = ST_OK;
    endfunction

    function automatic bit raise(logic [2:0] code, output t_dec r);
        err_on = 1;
        err_code = code;
        r = mk(8'd0, 0, code, 0);
        return 1;
    endfunction

    // Decodes one accepted word; returns 1 and the result when one is due.
    function automatic bit decode_word(t_word w, output t_dec r);
        logic [7:0] b, v;
        logic       last, dn;
        b = w.data_byte;
        last = w.last_byte;
        r = '0;
        if (err_on) begin
            r = mk(8'd0, 0, err_code, 0);
            return 1;
        end
        if (w.opcode == OP_DRAIN) begin
            if (ph != PH_COPY) return 0;
            v = hist_mem[cp_ptr];
            keep_byte(v);
            cp_ptr = cp_ptr + 1;
            dn = 0;
            if (match_left > 0) match_left--;
            if (match_left == 0) begin
                if (end_pend) begin
                    dn = 1;
                    close_block();
                end else begin
                    ph = PH_TOKEN;
                end
            end
            r = mk(v, 1, ST_OK, dn);
            return 1;
        end
        case (ph)
            PH_TOKEN: begin
                match_nib = b[3:0];
                if (b[7:4] == NIB_EXT) begin
                    lit_left = 15;
                    if (last) return raise(ST_LIT_OVER, r);
                    ph = PH_LIT_EXT;
                    return 0;
                end
                if (b[7:4] == 0) begin
                    if (last) begin
                        close_block();
                        r = mk(8'd0, 0, ST_OK, 1);
                        return 1;
                    end
                    ph = PH_OFF_LO;
                    return 0;
                end
                if (last) return raise(ST_LIT_OVER, r);
                lit_left = b[7:4];
                ph = PH_LITERALS;
                return 0;
            end
            PH_LIT_EXT: begin
                lit_left = sat_sum(lit_left, b);
                if (last) return raise(ST_LIT_OVER, r);
                if (b != BYTE_EXT) ph = PH_LITERALS;
                return 0;
            end
            PH_LITERALS: begin
                if (last && lit_left > 1) return raise(ST_LIT_OVER, r);
                keep_byte(b);
                if (lit_left > 0) lit_left--;
                if (lit_left == 0) begin
                    if (last) begin
                        close_block();
                        r = mk(b, 1, ST_OK, 1);
                        return 1;
                    end
                    ph = PH_OFF_LO;
                end
                r = mk(b, 1, ST_OK, 0);
                return 1;
            end
            PH_OFF_LO: begin
                offs = {8'd0, b};
                if (last) return raise(ST_TRUNC_OFF, r);
                ph = PH_OFF_HI;
                return 0;
            end
            PH_OFF_HI: begin
                offs = {b, offs[7:0]};
                if (offs == 0 || int'(offs) > emitted) return raise(ST_BAD_OFF, r);
                cp_ptr = wr_ptr - offs;
                match_left = match_nib + MINM;
                if (match_nib == NIB_EXT && !last) begin
                    ph = PH_MATCH_EXT;
                end else begin
                    ph = PH_COPY;
                    end_pend = last;
                end
                return 0;
            end
            PH_MATCH_EXT: begin
                match_left = sat_sum(match_left, b);
                if (b != BYTE_EXT || last) begin
                    ph = PH_COPY;
                    end_pend = last;
                end
                return 0;
            end
            default: return raise(ST_BUSY, r);
        endcase
    endfunction

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // The sender only lets go of a word after it is accepted, so the
    // predictor runs on every accepted word at the rising edge.
    always @(posedge i_clk) begin
        t_dec r;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            if (decode_word({in_ch.opcode, in_ch.data_byte, in_ch.last_byte}, r))
                expected_q.insert(expected_q.size(), r);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_dec got, want;
            words_decoded++;
            got = mk(out_ch.out_byte, out_ch.byte_valid, out_ch.status, out_ch.stream_done);
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected byte %h valid %b status %0d done %b,",
                        $time, want.out_byte, want.byte_valid, want.status, want.stream_done);
                    $display("      actual byte %h valid %b status %0d done %b",
                        got.out_byte, got.byte_valid, got.status, got.stream_done);
                    fail_count++;
                end
            end
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: random hold-off, or a long counted stall when requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 0;
        end else if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            out_ch.ready <= 0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG);
            $display("lz_block_stream_decoder_tb failed");
            $finish;
        end
    end

    // Offers one word and holds it until accepted, with random gaps before.
    // The word stays on the bus after acceptance until the next gap or word.
    task automatic send_word(t_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1;
        in_ch.opcode    <= w.opcode;
        in_ch.data_byte <= w.data_byte;
        in_ch.last_byte <= w.last_byte;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic put_byte(logic [7:0] b, logic last = 0);
        send_word({OP_BYTE, b, last});
    endtask

    task automatic put_drains(int n);
        repeat (n) send_word({OP_DRAIN, 8'($urandom), 1'b0});
    endtask

    // Emits a length extension run for an extra length beyond the nibble.
    task automatic put_ext(int extra, logic last_on_end);
        while (extra >= 255) begin
            put_byte(BYTE_EXT);
            extra -= 255;
        end
        put_byte(8'(extra), last_on_end);
    endtask

    // One well-formed sequence; nlit literals, optional match.
    task automatic put_sequence(int nlit, int mlen, bit with_match, bit ends_block);
        int ln, mn, k, off;
        ln = nlit >= 15 ? 15 : nlit;
        mn = (mlen - MINM) >= 15 ? 15 : mlen - MINM;
        put_byte({4'(ln), with_match ? 4'(mn) : 4'($urandom)},
            ends_block && !with_match && nlit == 0);
        if (ln == 15) put_ext(nlit - 15, 0);
        for (k = 0; k < nlit; k++)
            put_byte(8'($urandom), ends_block && !with_match && k == nlit - 1);
        if (!with_match) return;
        off = emitted < 1 ? 1 : $urandom_range(emitted < 40 ? emitted : 40, 1);
        if ($urandom_range(9) == 0 && emitted > 0) off = $urandom_range(emitted, 1);
        put_byte(8'(off));
        if (mn == 15) begin
            put_byte(8'(off >> 8));
            put_ext(mlen - MINM - 15, ends_block);
        end else begin
            put_byte(8'(off >> 8), ends_block);
        end
        put_drains(mlen);
    endtask

    task automatic random_block();
        int nseq, s, nlit, mlen;
        nseq = $urandom_range(4, 1);
        for (s = 0; s < nseq; s++) begin
            nlit = $urandom_range(3) == 0 ? $urandom_range(300, 0) : $urandom_range(6, 0);
            if (s == 0 && nlit == 0) nlit = 1;
            mlen = $urandom_range(4) == 0 ? $urandom_range(290, MINM)
                                          : $urandom_range(12, MINM);
            if (s == nseq - 1 && $urandom_range(2) == 0)
                put_sequence(nlit, mlen, 0, 1);
            else
                put_sequence(nlit, mlen, 1, s == nseq - 1);
        end
    endtask

    // Directed table, run once after the single reset; an error latches until
    // reset, so the error cases come last, after the table.
    t_row dir_rows[$];

    function automatic t_row rw(logic op, logic [7:0] b, logic last);
        t_row r;
        r = '0;
        r.w = {op, b, last};
        return r;
    endfunction

    function automatic t_row rx(logic op, logic [7:0] b, logic last, t_dec d);
        t_row r;
        r = rw(op, b, last);
        r.has_exp = 1;
        r.exp_dec = d;
        return r;
    endfunction

    initial begin
        int n, phase_id;
        t_dec tmp;
        i_rst_n = 0;
        in_ch.valid = 0; in_ch.opcode = OP_BYTE; in_ch.data_byte = 0; in_ch.last_byte = 0;
        out_ch.ready = 0;
        clear_decoder_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: idle drain, empty final token, literals 0x00/0xFF, an offset-one
        // overlapping copy, a match extension ending the block, a literal-only block.
        dir_rows.insert(dir_rows.size(), rw(OP_DRAIN, 8'hFF, 1));
        dir_rows.insert(dir_rows.size(), rx(OP_BYTE, 8'h0F, 1, mk(8'h00, 0, ST_OK, 1)));
        dir_rows.insert(dir_rows.size(), rw(OP_BYTE, 8'h2F, 0));
        dir_rows.insert(dir_rows.size(), rx(OP_BYTE, 8'h00, 0, mk(8'h00, 1, ST_OK, 0)));
        dir_rows.insert(dir_rows.size(), rx(OP_BYTE, 8'hFF, 0, mk(8'hFF, 1, ST_OK, 0)));
        dir_rows.insert(dir_rows.size(), rw(OP_BYTE, 8'h01, 0));
        dir_rows.insert(dir_rows.size(), rw(OP_BYTE, 8'h00, 0));
        dir_rows.insert(dir_rows.size(), rw(OP_BYTE, 8'h01, 1));
        for (n = 0; n < 20; n++) dir_rows.insert(dir_rows.size(), rw(OP_DRAIN, 8'h00, 0));
        dir_rows.insert(dir_rows.size(), rw(OP_BYTE, 8'h10, 0));
        dir_rows.insert(dir_rows.size(), rx(OP_BYTE, 8'hA5, 1, mk(8'hA5, 1, ST_OK, 1)));
        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].w);
            if (dir_rows[i].has_exp) begin
                // Check the typed-in value against the predictor's own view.
                tmp = expected_q[$];
                if (tmp !== dir_rows[i].exp_dec) begin
                    $display("%0t: table row %0d expected %h actual %h",
                        $time, i, dir_rows[i].exp_dec, tmp);
                    fail_count++;
                end
            end
        end
        wait_drained();

        // Random part in three idling settings with stalls on both sides.
        for (phase_id = 0; phase_id < 3; phase_id++) begin
            send_idle_pct = phase_id == 0 ? 34 : phase_id == 1 ? 77 : 0;
            recv_idle_pct = phase_id == 0 ? 77 : phase_id == 1 ? 34 : 0;
            if (phase_id == 2) stall_cycles = 300;
            n = words_sent;
            while (words_sent - n < 500) begin
                if ($urandom_range(19) == 0) begin
                    // Junk between blocks: stray drains are ignored.
                    put_drains($urandom_range(3, 1));
                end
                random_block();
                if ($urandom_range(7) == 0) wait_drained();
            end
            wait_drained();
        end

        // Error cases last, since an error latches until reset: a byte during
        // a copy latches busy, and every later word repeats that status.
        put_byte(8'h14); put_byte(8'h5A); put_byte(8'h01); put_byte(8'h00);
        put_byte(8'h33);
        put_drains(3);
        put_byte(8'h00, 1);
        wait_drained();
        $display("Covered %0d input words and %0d decoded words over directed,",
            words_sent, words_decoded);
        $display("random block streams, three idling settings, a long stall and errors.");
        if (fail_count == 0) begin
            $display("lz_block_stream_decoder_tb passed");
        end else begin
            $display("lz_block_stream_decoder_tb failed");
        end
        $finish;
    end
endmodule
